/* hw/rtl/ppw_pkg.sv */
// shared types and constants for the periodic point wrap block
// no dependencies; imported by every ppw_* module and the top level
package ppw_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NUM_AXES        = 3;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int MASK_WIDTH      = 3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PERIODIC_MASK = 3'd0,
        REG_X_MIN         = 3'd1,
        REG_X_MAX         = 3'd2,
        REG_Y_MIN         = 3'd3,
        REG_Y_MAX         = 3'd4,
        REG_Z_MIN         = 3'd5,
        REG_Z_MAX         = 3'd6
    } reg_index_t;

    // what the last stage does with one axis
    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_BELOW = 2'd1,
        MODE_ABOVE = 2'd2
    } wrap_mode_t;

    typedef struct packed {
        logic                        domain_error;
        wrap_mode_t [NUM_AXES-1:0]   mode;
    } wrap_ctrl_t;

endpackage

/* hw/rtl/ppw_front.sv */
// input stage: classifies each axis against its domain and forms the dividend
// depends on ppw_pkg
module ppw_front import ppw_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] in_coord,
    input  logic [MASK_WIDTH-1:0]                cfg_mask,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] cfg_min,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] cfg_max,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output wrap_ctrl_t                           out_ctrl,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0] out_data
);

    logic                                 valid_reg;
    wrap_ctrl_t                           ctrl_reg, ctrl_next;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] data_reg, data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        ctrl_next.domain_error = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            ctrl_next.mode[a] = MODE_PASS;
            data_next[a]      = in_coord[a];
            if (cfg_mask[a]) begin
                if ($signed(cfg_max[a]) <= $signed(cfg_min[a])) begin
                    ctrl_next.domain_error = 1'b1;
                end else if ($signed(in_coord[a]) < $signed(cfg_min[a])) begin
                    ctrl_next.mode[a] = MODE_BELOW;
                    data_next[a]      = cfg_min[a] - in_coord[a];
                end else if ($signed(in_coord[a]) >= $signed(cfg_max[a])) begin
                    ctrl_next.mode[a] = MODE_ABOVE;
                    data_next[a]      = in_coord[a] - cfg_max[a];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctrl_reg <= ctrl_next;
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_data  = data_reg;

endmodule

/* hw/rtl/ppw_cell.sv */
// one restoring remainder step for all three axes, one dividend bit per cell
// depends on ppw_pkg
module ppw_cell import ppw_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] size,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  wrap_ctrl_t                           in_ctrl,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] in_data,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] in_rem,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output wrap_ctrl_t                           out_ctrl,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0] out_data,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0] out_rem
);

    logic                                 valid_reg;
    wrap_ctrl_t                           ctrl_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] data_reg, data_next;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_AXES-1:0][COORD_WIDTH:0]   trial;
    logic [NUM_AXES-1:0][COORD_WIDTH:0]   diff;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            // shift in the next dividend bit, subtract the period if it fits
            trial[a] = {in_rem[a], in_data[a][COORD_WIDTH-1]};
            diff[a]  = trial[a] - {1'b0, size[a]};
            if (in_ctrl.mode[a] == MODE_PASS) begin
                data_next[a] = in_data[a];
                rem_next[a]  = in_rem[a];
            end else begin
                data_next[a] = {in_data[a][COORD_WIDTH-2:0], 1'b0};
                if (trial[a] >= {1'b0, size[a]}) begin
                    rem_next[a] = diff[a][COORD_WIDTH-1:0];
                end else begin
                    rem_next[a] = trial[a][COORD_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctrl_reg <= in_ctrl;
            data_reg <= data_next;
            rem_reg  <= rem_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_data  = data_reg;
    assign out_rem   = rem_reg;

    // pass-through axes never accumulate a remainder
    a_pass_rem_x: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready && in_valid && in_ctrl.mode[0] == MODE_PASS
        |=> out_data[0] == $past(in_data[0]) && out_rem[0] == $past(in_rem[0]))
        else $error("pass axis x altered in cell");

    a_pass_rem_y: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready && in_valid && in_ctrl.mode[1] == MODE_PASS
        |=> out_data[1] == $past(in_data[1]) && out_rem[1] == $past(in_rem[1]))
        else $error("pass axis y altered in cell");

    a_pass_rem_z: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready && in_valid && in_ctrl.mode[2] == MODE_PASS
        |=> out_data[2] == $past(in_data[2]) && out_rem[2] == $past(in_rem[2]))
        else $error("pass axis z altered in cell");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(ctrl_reg))
        else $error("cell dropped a stalled item");

endmodule

/* hw/rtl/ppw_back.sv */
// output stage: turns each remainder into the wrapped coordinate, output register
// depends on ppw_pkg
module ppw_back import ppw_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] cfg_min,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] cfg_max,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  wrap_ctrl_t                           in_ctrl,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] in_data,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] in_rem,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [NUM_AXES-1:0][COORD_WIDTH-1:0] out_coord,
    output logic                                 out_error
);

    logic                                 valid_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] coord_reg, coord_next;
    logic                                 error_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            unique case (in_ctrl.mode[a])
                MODE_BELOW: begin
                    // a zero remainder lands on the last value inside the domain
                    if (in_rem[a] == '0) begin
                        coord_next[a] = cfg_max[a] - COORD_WIDTH'(1);
                    end else begin
                        coord_next[a] = cfg_max[a] - in_rem[a];
                    end
                end
                MODE_ABOVE: coord_next[a] = cfg_min[a] + in_rem[a];
                default:    coord_next[a] = in_data[a];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            coord_reg <= coord_next;
            error_reg <= in_ctrl.domain_error;
        end
    end

    assign out_valid = valid_reg;
    assign out_coord = coord_reg;
    assign out_error = error_reg;

endmodule

/* hw/rtl/periodic_point_wrap_3d.sv */
// top level of the periodic point wrap block: config registers and the cell row
// depends on ppw_pkg, ppw_front, ppw_cell, ppw_back

// Wraps each periodic axis of a 3D fixed-point point into [min, max); an empty or
// inverted domain on a periodic axis raises domain_error instead. One item is
// accepted per clock cycle unless the output stalls, and each item gives one
// result after an input stage, one remainder cell per coordinate bit, and an
// output register; each cell takes one dividend bit for all three axes. A
// stalled output backs up the row stage by stage, so empty stages still take
// items. The user must write configuration through the cfg port while no item
// is in flight, unchecked by the block; writes to indexes past z_max are ignored.
module periodic_point_wrap_3d import ppw_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [COORD_WIDTH-1:0]          cfg_data,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,  // x_in, y_in, z_in, zero pad
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,  // x_out, y_out, z_out, zero pad
    output logic                            m_tuser   // domain_error
);

    localparam int NUM_CELLS = COORD_WIDTH;

    logic [MASK_WIDTH-1:0]                mask_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] min_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] max_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] size;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] coord_in;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] coord_out;

    logic                                 valid_chain [0:NUM_CELLS];
    logic                                 ready_chain [0:NUM_CELLS];
    wrap_ctrl_t                           ctrl_chain  [0:NUM_CELLS];
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] data_chain  [0:NUM_CELLS];
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] rem_chain   [0:NUM_CELLS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            min_reg  <= '0;
            max_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_index_t'(cfg_index))
                REG_PERIODIC_MASK: mask_reg   <= cfg_data[MASK_WIDTH-1:0];
                REG_X_MIN:         min_reg[0] <= cfg_data;
                REG_X_MAX:         max_reg[0] <= cfg_data;
                REG_Y_MIN:         min_reg[1] <= cfg_data;
                REG_Y_MAX:         max_reg[1] <= cfg_data;
                REG_Z_MIN:         min_reg[2] <= cfg_data;
                REG_Z_MAX:         max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // the period only matters where max is above min, so it fits the coordinate width
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            size[a] = max_reg[a] - min_reg[a];
        end
    end

    assign coord_in = s_tdata[NUM_AXES*COORD_WIDTH-1:0];

    ppw_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_coord  (coord_in),
        .cfg_mask  (mask_reg),
        .cfg_min   (min_reg),
        .cfg_max   (max_reg),
        .out_valid (valid_chain[0]),
        .out_ready (ready_chain[0]),
        .out_ctrl  (ctrl_chain[0]),
        .out_data  (data_chain[0])
    );

    assign rem_chain[0] = '0;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        ppw_cell #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .size      (size),
            .in_valid  (valid_chain[k]),
            .in_ready  (ready_chain[k]),
            .in_ctrl   (ctrl_chain[k]),
            .in_data   (data_chain[k]),
            .in_rem    (rem_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_ready (ready_chain[k+1]),
            .out_ctrl  (ctrl_chain[k+1]),
            .out_data  (data_chain[k+1]),
            .out_rem   (rem_chain[k+1])
        );
    end

    ppw_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_min   (min_reg),
        .cfg_max   (max_reg),
        .in_valid  (valid_chain[NUM_CELLS]),
        .in_ready  (ready_chain[NUM_CELLS]),
        .in_ctrl   (ctrl_chain[NUM_CELLS]),
        .in_data   (data_chain[NUM_CELLS]),
        .in_rem    (rem_chain[NUM_CELLS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_coord (coord_out),
        .out_error (m_tuser)
    );

    always_comb begin
        m_tdata                           = '0;
        m_tdata[NUM_AXES*COORD_WIDTH-1:0] = coord_out;
    end

endmodule

/* bench/tb_periodic_point_wrap_3d.sv */
`timescale 1ns / 100ps
// testbench for periodic_point_wrap_3d: streams 3d points through several wrap domains
// and checks every wrapped point against a predictor kept in the bench
// depends on ppw_pkg and the periodic_point_wrap_3d rtl
module tb_periodic_point_wrap_3d;
    import ppw_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int TDATA_W = ((3 * CW + 7) / 8) * 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 3'd7;
    localparam longint COORD_MIN = -(longint'(1) << (CW - 1));
    localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
    localparam int LONG_HOLD = 150;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = CW + 8;
    localparam int REPORT_LIMIT = 10;
    localparam int RAND_PHASES = 11;
    localparam int PHASE_ITEMS = 44;
    localparam int PRESSURE_PHASE = 3;

    typedef logic signed [CW-1:0] coord_t;
    typedef coord_t [2:0] point_t;  // [0] x, [1] y, [2] z
    typedef struct packed {
        logic   err;
        point_t p;
    } wrap_result_t;
    typedef struct packed {
        logic [CW-1:0] mask_word;
        point_t        lo;
        point_t        hi;
    } domain_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CW-1:0]              cfg_data = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [TDATA_W-1:0]         s_tdata = '0;   // x_in, y_in, z_in
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [TDATA_W-1:0]         m_tdata;        // x_out, y_out, z_out
    logic                       m_tuser;        // domain_error

    // predictor copy of the register file
    logic [MASK_WIDTH-1:0] wrap_mask = '0;
    longint                axis_lo [3] = '{0, 0, 0};
    longint                axis_hi [3] = '{0, 0, 0};

    point_t       pending_points [$];
    wrap_result_t expected_wraps [$];

    logic in_taken = 1'b0;
    int   tx_gap = 0;
    int   rx_wait = 0;
    bit   tx_idle_on = 1'b1;
    bit   rx_idle_on = 1'b1;
    bit   tx_steady = 1'b0;
    bit   long_hold_req = 1'b0;
    bit   long_hold_done = 1'b0;
    int   idle_cycles = 0;
    int   mismatch_count = 0;

    periodic_point_wrap_3d #(.COORD_WIDTH(CW)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic wrap_result_t wrap_point(point_t pt);
        wrap_result_t res;
        longint v, span, rem;
        res.err = 1'b0;
        for (int a = 0; a < 3; a++) begin
            v = $signed(pt[a]);
            span = axis_hi[a] - axis_lo[a];
            if (wrap_mask[a]) begin
                if (span <= 0) begin
                    res.err = 1'b1;
                end else if (v < axis_lo[a]) begin
                    rem = (axis_lo[a] - v) % span;
                    // a whole number of periods below lands on the top lsb
                    v = (rem == 0) ? axis_hi[a] - 1 : axis_hi[a] - rem;
                end else if (v >= axis_hi[a]) begin
                    v = axis_lo[a] + (v - axis_hi[a]) % span;
                end
            end
            res.p[a] = coord_t'(v);
        end
        return res;
    endfunction

    function automatic int idle_gap(bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint any_coord();
        coord_t c;
        c = coord_t'($urandom);
        return c;
    endfunction

    function automatic domain_t random_domain();
        domain_t d;
        longint a, b;
        d.mask_word = CW'($urandom);
        for (int i = 0; i < 3; i++) begin
            a = any_coord();
            b = any_coord();
            case ($urandom_range(0, 9))
                0: b = a;
                1: begin
                    // inverted bounds
                    if (a < b) begin
                        a = a ^ b;
                        b = a ^ b;
                        a = a ^ b;
                    end
                end
                2: begin
                    a = COORD_MIN;
                    b = COORD_MAX;
                end
                3: begin
                    if (a == COORD_MAX)
                        a = a - 1;
                    b = a + 1;
                end
                4, 5, 6: begin
                    a = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
                    b = a + longint'($urandom_range(1, 1 << 22));
                end
                default: begin
                    if (a > b) begin
                        a = a ^ b;
                        b = a ^ b;
                        a = a ^ b;
                    end
                end
            endcase
            d.lo[i] = coord_t'(a);
            d.hi[i] = coord_t'(b);
        end
        return d;
    endfunction

    function automatic longint axis_sample(longint lo, longint hi);
        longint span, c, off;
        span = (hi > lo) ? hi - lo : 1;
        off = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom) % span;
        case ($urandom_range(0, 9))
            0: c = any_coord();
            1: begin
                case ($urandom_range(0, 3))
                    0: c = COORD_MIN;
                    1: c = COORD_MAX;
                    2: c = 0;
                    default: c = -1;
                endcase
            end
            2: c = lo + longint'($urandom_range(0, 4)) - 2;
            3: c = hi + longint'($urandom_range(0, 4)) - 2;
            4, 5: c = lo + longint'($urandom) % span;
            6, 7: c = lo - longint'($urandom_range(0, 4)) * span - off;
            default: c = hi + longint'($urandom_range(0, 4)) * span + off;
        endcase
        if (c < COORD_MIN || c > COORD_MAX)
            c = any_coord();
        return c;
    endfunction

    task automatic queue_point(longint x, longint y, longint z);
        point_t pt;
        pt[0] = coord_t'(x);
        pt[1] = coord_t'(y);
        pt[2] = coord_t'(z);
        pending_points.push_back(pt);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (pending_points.size() != 0 || s_tvalid || expected_wraps.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_PERIODIC_MASK: wrap_mask = val[MASK_WIDTH-1:0];
            REG_X_MIN: axis_lo[0] = $signed(val);
            REG_X_MAX: axis_hi[0] = $signed(val);
            REG_Y_MIN: axis_lo[1] = $signed(val);
            REG_Y_MAX: axis_hi[1] = $signed(val);
            REG_Z_MIN: axis_lo[2] = $signed(val);
            REG_Z_MAX: axis_hi[2] = $signed(val);
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_domain(domain_t d);
        wait_drained();
        write_reg(REG_PERIODIC_MASK, d.mask_word);
        write_reg(REG_X_MIN, d.lo[0]);
        write_reg(REG_X_MAX, d.hi[0]);
        write_reg(REG_Y_MIN, d.lo[1]);
        write_reg(REG_Y_MAX, d.hi[1]);
        write_reg(REG_Z_MIN, d.lo[2]);
        write_reg(REG_Z_MAX, d.hi[2]);
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else if (s_tvalid && !in_taken) begin
            // item still waiting for the block
        end else if (tx_gap > 0) begin
            s_tvalid <= 1'b0;
            tx_gap <= tx_gap - 1;
        end else if (pending_points.size() != 0) begin
            s_tdata <= TDATA_W'(pending_points.pop_front());
            s_tvalid <= 1'b1;
            tx_gap <= tx_steady ? 0 : idle_gap(tx_idle_on);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else if (long_hold_req && !long_hold_done) begin
            // long hold-off so the row fills and the input stalls
            m_tready <= 1'b0;
            rx_wait <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
            rx_wait <= idle_gap(rx_idle_on);
        end
    end

    // monitor: predict on input, compare on output
    always @(posedge aclk) begin : result_check
        wrap_result_t got, want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                expected_wraps.push_back(wrap_point(s_tdata[3*CW-1:0]));
            if (m_tvalid && m_tready) begin
                got.p = m_tdata[3*CW-1:0];
                got.err = m_tuser;
                if (expected_wraps.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected item: x %h y %h z %h err %b",
                                 got.p[0], got.p[1], got.p[2], got.err);
                end else begin
                    want = expected_wraps.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("mismatch: exp x %h y %h z %h err %b, got x %h y %h z %h err %b",
                                     want.p[0], want.p[1], want.p[2], want.err,
                                     got.p[0], got.p[1], got.p[2], got.err);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("periodic_point_wrap_3d verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        domain_t d;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset registers: nothing wraps
        queue_point(0, COORD_MAX, COORD_MIN);
        queue_point(-1, 1, 32'h1234_5678);

        // x in [-10, 10), y in [1, 4), z in [COORD_MIN, COORD_MAX)
        d.mask_word = '1;
        d.lo[0] = coord_t'(-655360);
        d.hi[0] = coord_t'(655360);
        d.lo[1] = coord_t'(65536);
        d.hi[1] = coord_t'(262144);
        d.lo[2] = coord_t'(COORD_MIN);
        d.hi[2] = coord_t'(COORD_MAX);
        apply_domain(d);
        queue_point(0, 65536, 0);
        queue_point(-655360, 65536, COORD_MIN);
        queue_point(655360, 262144, COORD_MAX);
        queue_point(-1966080, -131072, COORD_MAX - 1);
        queue_point(-655361, 0, -1);
        queue_point(655360 + 5 * 1310720 + 7, 262144 + 3 * 196608 + 99, 12345);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(-1, -1, 0);
        queue_point(655359, 262143, COORD_MAX - 1);

        // one-lsb period on x, empty y domain, inverted z domain
        d.lo[0] = coord_t'(100);
        d.hi[0] = coord_t'(101);
        d.lo[1] = coord_t'(0);
        d.hi[1] = coord_t'(0);
        d.lo[2] = coord_t'(COORD_MAX);
        d.hi[2] = coord_t'(COORD_MIN);
        apply_domain(d);
        queue_point(100, 0, 0);
        queue_point(99, 5, COORD_MIN);
        queue_point(101, COORD_MIN, COORD_MAX);
        queue_point(COORD_MIN, -7, 3);
        queue_point(COORD_MAX, COORD_MAX, -1);

        // no periodic axis, junk in the upper mask bits, a write past z_max
        d.mask_word = {{(CW - MASK_WIDTH){1'b1}}, {MASK_WIDTH{1'b0}}};
        d.lo[0] = coord_t'(COORD_MAX);
        d.hi[0] = coord_t'(COORD_MIN);
        d.lo[1] = coord_t'(0);
        d.hi[1] = coord_t'(65536);
        d.lo[2] = coord_t'(COORD_MIN);
        d.hi[2] = coord_t'(COORD_MAX);
        apply_domain(d);
        write_reg(REG_SPARE, CW'($urandom));
        queue_point(COORD_MIN, 70000, 5);
        queue_point(COORD_MAX, -3, COORD_MAX);
        queue_point(42, 0, -42);

        // x and z periodic; empty y domain raises nothing when y is not periodic
        d.mask_word = CW'(5);
        d.lo[0] = coord_t'(-65536);
        d.hi[0] = coord_t'(65536);
        d.lo[1] = coord_t'(1000);
        d.hi[1] = coord_t'(1000);
        d.lo[2] = coord_t'(0);
        d.hi[2] = coord_t'(3);
        apply_domain(d);
        queue_point(200000, 12345, -7);
        queue_point(-200000, 1000, 7);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            d = random_domain();
            if (ph == 0)
                d.mask_word[MASK_WIDTH-1:0] = '1;
            apply_domain(d);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            tx_steady = (ph == PRESSURE_PHASE);
            if (ph == PRESSURE_PHASE)
                long_hold_req = 1'b1;
            repeat ((ph == PRESSURE_PHASE) ? 2 * PHASE_ITEMS : PHASE_ITEMS)
                queue_point(axis_sample($signed(d.lo[0]), $signed(d.hi[0])),
                            axis_sample($signed(d.lo[1]), $signed(d.hi[1])),
                            axis_sample($signed(d.lo[2]), $signed(d.hi[2])));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_wraps.size() == 0)
            $display("periodic_point_wrap_3d verification clean");
        else
            $display("periodic_point_wrap_3d verification failed");
        $finish;
    end

endmodule
